// ===== src/ic3_pkg.sv =====
// Shared types and constants for the 3x3 fixed-kernel convolution block.
// Holds the kernel and register codes and the divider reciprocals.
// No dependencies.
`default_nettype none

package ic3_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_DATA_W = 11;
	localparam int MAX_HEIGHT = 1024;
	localparam int COORD_W    = 10;

	// Sum of the kernel taps, wide enough for every mode before the divide.
	localparam int SUM_W = 14;

	// Gaussian: sum/24 is q/6 where q = t1+m0+2*m1+m2+b1. Exact for q < 8192.
	localparam int GAUSS_RECIP = 2731;
	localparam int GAUSS_SHIFT = 14;
	// Box average: sum/9, exact for sums below 32768.
	localparam int BOX_RECIP   = 3641;
	localparam int BOX_SHIFT   = 15;

	typedef enum logic [1:0] {
		KM_HLINE  = 2'd0,
		KM_GAUSS  = 2'd1,
		KM_EMBOSS = 2'd2,
		KM_BOX    = 2'd3
	} kernel_mode_t;

	typedef enum logic [1:0] {
		REG_KERNEL_MODE  = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/image_conv3x3_fixed_kernels.sv =====
// Top level of the 3x3 fixed-kernel convolution over a raster pixel stream.
// Holds the line-store memory, the window, the kernel pipeline and the config registers.
// Depends on ic3_pkg.
// Throughput: one pixel beat per clock unless a held out_stall fills the pipeline, set by the
// single line-store read-modify-write. A result passes the stage 1, 2, 3 and output registers.
// Reset (arst_n low, asynchronous): counters, window and valids clear, mode returns to box
// average and width and height to 1024. The line store is not cleared; its output is only used
// where earlier rows have written it.
`default_nettype none

module image_conv3x3_fixed_kernels
	import ic3_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PIX_W-1:0]      pixel,
	input  wire logic                  frame_start,

	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [PIX_W-1:0]           filtered,
	output logic [COORD_W-1:0]         out_row,
	output logic [COORD_W-1:0]         out_col,
	output logic                       last_result
);

	// Column index width, and the width that can hold the row length itself.
	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = CFG_DATA_W;
	localparam int LW = 2 * PIX_W;

	// ------------------------------------------------------------------
	// Configuration registers. The port never pushes back.
	// ------------------------------------------------------------------
	kernel_mode_t          kernel_mode_q;
	logic [CFG_DATA_W-1:0] image_width_q;
	logic [CFG_DATA_W-1:0] image_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_mode_q  <= KM_BOX;
			image_width_q  <= CFG_DATA_W'(1024);
			image_height_q <= CFG_DATA_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KERNEL_MODE:  kernel_mode_q  <= kernel_mode_t'(cfg_data[1:0]);
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective plane size: out-of-range values are pinned to the legal range.
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	always_comb begin
		if (image_width_q < CFG_DATA_W'(3)) begin
			w_eff = WW'(3);
		end else if (int'(image_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width_q);
		end
		if (image_height_q < CFG_DATA_W'(3)) begin
			h_eff = HW'(3);
		end else if (int'(image_height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = image_height_q;
		end
	end

	// ------------------------------------------------------------------
	// Pipeline handshake. Each stage takes a new beat when it is empty or
	// its content moves on, so bubbles absorb output stalls.
	// ------------------------------------------------------------------
	logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
	logic s1_take, s2_take, s3_take, out_take;
	logic in_acc;
	logic s1_fire;

	assign out_take = !out_valid_q || !out_stall;
	assign s3_take  = !s3_valid_q || out_take;
	assign s2_take  = !s2_valid_q || s3_take;
	assign s1_take  = !s1_valid_q || s2_take;
	assign in_stall = !s1_take;
	assign in_acc   = in_valid && s1_take;
	// The beat in stage 1 updates the line store and window exactly once, when it leaves.
	assign s1_fire  = s1_valid_q && s2_take;

	// ------------------------------------------------------------------
	// Raster counters, evaluated for the beat being accepted.
	// ------------------------------------------------------------------
	logic [CW-1:0]      col_q;
	logic [COORD_W-1:0] row_q;
	logic [CW-1:0]      c0;
	logic [COORD_W-1:0] r0;
	logic [WW-1:0]      c0_inc;
	logic [HW-1:0]      r0_inc;
	logic               emit0;
	logic               last0;
	logic [CW+COORD_W-1:0] col_m1_ext;

	always_comb begin
		c0 = frame_start ? '0 : col_q;
		r0 = frame_start ? '0 : row_q;
		if (WW'(c0) >= w_eff) begin
			c0 = '0;
		end
		if (HW'(r0) >= h_eff) begin
			r0 = '0;
		end
		c0_inc     = WW'(c0) + WW'(1);
		r0_inc     = HW'(r0) + HW'(1);
		emit0      = (r0 >= COORD_W'(2)) && (c0 >= CW'(2));
		last0      = (HW'(r0) == h_eff - HW'(1)) && (WW'(c0) == w_eff - WW'(1));
		col_m1_ext = (CW+COORD_W)'(c0 - CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (c0_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (r0_inc >= h_eff) ? '0 : COORD_W'(r0_inc);
			end else begin
				col_q <= CW'(c0_inc);
				row_q <= r0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Line store: one word per column, {row r-1, row r-2}. Read on accept,
	// written back {pixel, row r-1} when the beat leaves stage 1.
	// ------------------------------------------------------------------
	logic [LW-1:0] line_mem [MAX_WIDTH];
	logic [LW-1:0] line_rd_q;
	logic [LW-1:0] wr_data;
	logic          wr_en;

	logic [PIX_W-1:0]   pix_s1;
	logic [CW-1:0]      col_s1;
	logic               emit_s1;
	logic               last_s1;
	logic [COORD_W-1:0] orow_s1;
	logic [COORD_W-1:0] ocol_s1;
	logic               fwd_s1;
	logic [LW-1:0]      fwd_data_s1;
	logic [LW-1:0]      line_word;
	logic [PIX_W-1:0]   top_px, mid_px;

	// A back-to-back beat on the same column would read the word before the
	// write lands, so the written word is forwarded instead.
	assign line_word = fwd_s1 ? fwd_data_s1 : line_rd_q;
	assign mid_px    = line_word[LW-1:PIX_W];
	assign top_px    = line_word[PIX_W-1:0];
	assign wr_en     = s1_fire;
	assign wr_data   = {pix_s1, mid_px};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[col_s1] <= wr_data;
		end
		if (in_acc) begin
			line_rd_q <= line_mem[c0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1      <= pixel;
			col_s1      <= c0;
			emit_s1     <= emit0;
			last_s1     <= last0;
			orow_s1     <= r0 - COORD_W'(1);
			ocol_s1     <= col_m1_ext[COORD_W-1:0];
			fwd_s1      <= wr_en && (col_s1 == c0);
			fwd_data_s1 <= wr_data;
		end
	end

	// ------------------------------------------------------------------
	// Window: three columns of three rows, row 0 on top. The newest column
	// enters on the right when the stage-1 beat leaves.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (s1_fire) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= top_px;
			win_q[1][2] <= mid_px;
			win_q[2][2] <= pix_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: tap sum. The window cannot move while stage 2 holds a beat,
	// so it is read in place.
	// ------------------------------------------------------------------
	logic               last_s2;
	logic [COORD_W-1:0] orow_s2, ocol_s2;
	logic signed [SUM_W-1:0] tap [3][3];
	logic signed [SUM_W-1:0] sum2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				tap[i][j] = $signed(SUM_W'(win_q[i][j]));
			end
		end
		case (kernel_mode_q)
			KM_HLINE:  sum2 = (tap[2][0] + (tap[2][1] <<< 1) + tap[2][2])
			                - (tap[0][0] + (tap[0][1] <<< 1) + tap[0][2]);
			// The factor of four of the cross is folded into the divide by six.
			KM_GAUSS:  sum2 = tap[0][1] + tap[1][0] + (tap[1][1] <<< 1) + tap[1][2]
			                + tap[2][1];
			KM_EMBOSS: sum2 = tap[0][0] + tap[0][1] - tap[0][2] + tap[1][0] + tap[1][1]
			                - tap[1][2] + tap[2][0] - tap[2][1] - tap[2][2];
			default:   sum2 = tap[0][0] + tap[0][1] + tap[0][2] + tap[1][0] + tap[1][1]
			                + tap[1][2] + tap[2][0] + tap[2][1] + tap[2][2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			last_s2 <= last_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: Gaussian and box divide by reciprocal multiply; the other modes clamp to a byte.
	// ------------------------------------------------------------------
	logic signed [SUM_W-1:0] sum_s3;
	logic                    last_s3;
	logic [COORD_W-1:0]      orow_s3, ocol_s3;
	logic [23:0]             gauss_prod;
	logic [23:0]             box_prod;
	logic [PIX_W-1:0]        result3;

	always_ff @(posedge clk) begin
		if (s3_take && s2_valid_q) begin
			sum_s3  <= sum2;
			last_s3 <= last_s2;
			orow_s3 <= orow_s2;
			ocol_s3 <= ocol_s2;
		end
	end

	always_comb begin
		gauss_prod = 24'(sum_s3[10:0]) * 24'(GAUSS_RECIP);
		box_prod   = 24'(sum_s3[11:0]) * 24'(BOX_RECIP);
		case (kernel_mode_q)
			KM_GAUSS: result3 = gauss_prod[GAUSS_SHIFT +: PIX_W];
			KM_BOX:   result3 = box_prod[BOX_SHIFT +: PIX_W];
			default: begin
				if (sum_s3 < 0) begin
					result3 = '0;
				end else if (sum_s3 > SUM_W'(255)) begin
					result3 = '1;
				end else begin
					result3 = sum_s3[PIX_W-1:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_take && s3_valid_q) begin
			filtered    <= result3;
			out_row     <= orow_s3;
			out_col     <= ocol_s3;
			last_result <= last_s3;
		end
	end

	// Valid chain. Only interior pixels go past stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			s3_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_take) begin
				s1_valid_q <= in_valid;
			end
			if (s2_take) begin
				s2_valid_q <= s1_valid_q && emit_s1;
			end
			if (s3_take) begin
				s3_valid_q <= s2_valid_q;
			end
			if (out_take) begin
				out_valid_q <= s3_valid_q;
			end
		end
	end

	assign out_valid = out_valid_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	a_no_overwrite_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (!s1_valid_q || s1_fire))
		else $error("stage 1 beat overwritten before its line-store write");

	a_forward_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && wr_en && (col_s1 == c0)) |=> fwd_s1)
		else $error("same-column back-to-back beat not forwarded");

	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> ((orow_s2 != '0) && (ocol_s2 != '0)))
		else $error("border pixel reached the kernel stage");

	a_last_position: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last0) |-> emit0)
		else $error("plane end flagged on a pixel that emits nothing");

endmodule

`default_nettype wire
